>>> rtl/core/arp_pkg.sv
// Shared types, codes and helper functions of the AArch64 relocation patcher.
package arp_pkg;

   localparam int unsigned OP_W    = 11;
   localparam int unsigned ADDR_W  = 64;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned ALIGN_W = 13;
   localparam int unsigned TCB_W   = 14;

   localparam logic [ADDR_W-1:0] PAGE_LOW  = 64'hfff;
   localparam logic [ADDR_W-1:0] TCB_BYTES = 64'd16;
   localparam logic [TCB_W-1:0]  TCB_RESET = 14'd16;

   // Relocation type numbers.
   localparam logic [OP_W-1:0] OP_NONE_GENERIC       = 11'd0;
   localparam logic [OP_W-1:0] OP_NONE               = 11'd256;
   localparam logic [OP_W-1:0] OP_ABS64              = 11'd257;
   localparam logic [OP_W-1:0] OP_ABS32              = 11'd258;
   localparam logic [OP_W-1:0] OP_ABS16              = 11'd259;
   localparam logic [OP_W-1:0] OP_PREL64             = 11'd260;
   localparam logic [OP_W-1:0] OP_PREL32             = 11'd261;
   localparam logic [OP_W-1:0] OP_PREL16             = 11'd262;
   localparam logic [OP_W-1:0] OP_LD_PREL_LO19       = 11'd273;
   localparam logic [OP_W-1:0] OP_ADR_PREL_LO21      = 11'd274;
   localparam logic [OP_W-1:0] OP_ADR_PREL_PG_HI21   = 11'd275;
   localparam logic [OP_W-1:0] OP_ADR_PREL_PG_HI21_NC = 11'd276;
   localparam logic [OP_W-1:0] OP_ADD_ABS_LO12_NC    = 11'd277;
   localparam logic [OP_W-1:0] OP_LDST8_ABS_LO12_NC  = 11'd278;
   localparam logic [OP_W-1:0] OP_TSTBR14            = 11'd279;
   localparam logic [OP_W-1:0] OP_CONDBR19           = 11'd280;
   localparam logic [OP_W-1:0] OP_JUMP26             = 11'd282;
   localparam logic [OP_W-1:0] OP_CALL26             = 11'd283;
   localparam logic [OP_W-1:0] OP_LDST16_ABS_LO12_NC = 11'd284;
   localparam logic [OP_W-1:0] OP_LDST32_ABS_LO12_NC = 11'd285;
   localparam logic [OP_W-1:0] OP_LDST64_ABS_LO12_NC = 11'd286;
   localparam logic [OP_W-1:0] OP_LDST128_ABS_LO12_NC = 11'd299;
   localparam logic [OP_W-1:0] OP_ADR_GOT_PAGE       = 11'd311;
   localparam logic [OP_W-1:0] OP_LD64_GOT_LO12_NC   = 11'd312;
   localparam logic [OP_W-1:0] OP_LD64_GOTPAGE_LO15  = 11'd313;
   localparam logic [OP_W-1:0] OP_TLSLE_ADD_TPREL_HI12 = 11'd549;
   localparam logic [OP_W-1:0] OP_TLSLE_ADD_TPREL_LO12_NC = 11'd551;
   localparam logic [OP_W-1:0] OP_TLSDESC_ADR_PAGE21 = 11'd562;
   localparam logic [OP_W-1:0] OP_TLSDESC_LD64_LO12  = 11'd563;
   localparam logic [OP_W-1:0] OP_TLSDESC_ADD_LO12   = 11'd564;
   localparam logic [OP_W-1:0] OP_TLSDESC_CALL       = 11'd569;

   // Write sizes and status codes.
   localparam logic [1:0] SIZE_NONE = 2'd0;
   localparam logic [1:0] SIZE_16   = 2'd1;
   localparam logic [1:0] SIZE_32   = 2'd2;
   localparam logic [1:0] SIZE_64   = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_OVF   = 2'd1;
   localparam logic [1:0] STAT_UNSUP = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_GOT_BASE  = 1'b0;
   localparam logic CSR_SEG_ALIGN = 1'b1;

   typedef enum logic [1:0] {RES_NULL, RES_DATA, RES_INSN, RES_UNSUP} res_kind_type;

   typedef enum logic [2:0] {
      SRC_S, SRC_PREL, SRC_PAGE, SRC_GPAGE, SRC_G, SRC_GREL, SRC_TLS
   } src_type;

   typedef enum logic [3:0] {
      RNG_NONE, RNG_W32, RNG_W16, RNG_S21, RNG_S33, RNG_S16, RNG_S28, RNG_U15, RNG_U24
   } rng_type;

   typedef enum logic [2:0] {IMM_26, IMM_19, IMM_14, IMM_12, IMM_ADR} imm_slot_type;

   typedef struct packed {
      res_kind_type res;
      logic [1:0]   wsize;
      src_type      src;
      rng_type      rng;
      logic         need_g;
      logic         branch;
      logic [3:0]   lsb;
      logic [4:0]   len;
      imm_slot_type imm;
   } dec_type;

   // Stage 1 to stage 2: decoded type plus every candidate value.
   typedef struct packed {
      dec_type           dec;
      logic [ADDR_W-1:0] s;
      logic [ADDR_W-1:0] prel;
      logic [ADDR_W-1:0] page;
      logic [ADDR_W-1:0] ven_off;
      logic              v_zero;
      logic [ADDR_W-1:0] gpage;
      logic [ADDR_W-1:0] g;
      logic              g_nz;
      logic [ADDR_W-1:0] grel;
      logic [ADDR_W-1:0] tls;
      logic [WORD_W-1:0] old_word;
   } s1_type;

   // Stage 2 to stage 3: chosen value and verdict.
   typedef struct packed {
      res_kind_type      res;
      logic [1:0]        wsize;
      logic              ok;
      logic              ven;
      logic [ADDR_W-1:0] x;
      logic [3:0]        lsb;
      logic [4:0]        len;
      imm_slot_type      imm;
      logic [WORD_W-1:0] old_word;
   } s2_type;

   function automatic dec_type make_insn(src_type src, rng_type rng, logic need_g,
                                         logic [3:0] lsb, logic [4:0] len,
                                         imm_slot_type imm);
      dec_type d;
      d.res    = RES_INSN;
      d.wsize  = SIZE_32;
      d.src    = src;
      d.rng    = rng;
      d.need_g = need_g;
      d.branch = 1'b0;
      d.lsb    = lsb;
      d.len    = len;
      d.imm    = imm;
      return d;
   endfunction

   function automatic dec_type make_data(src_type src, rng_type rng, logic [1:0] wsize);
      dec_type d;
      d        = make_insn(src, rng, 1'b0, 4'd0, 5'd0, IMM_12);
      d.res    = RES_DATA;
      d.wsize  = wsize;
      return d;
   endfunction

   function automatic dec_type decode(logic [OP_W-1:0] op);
      dec_type d;
      d = make_data(SRC_S, RNG_NONE, SIZE_NONE);
      d.res = RES_UNSUP;
      unique case (op)
         OP_NONE_GENERIC, OP_NONE, OP_TLSDESC_CALL: d.res = RES_NULL;
         OP_ABS64:  d = make_data(SRC_S, RNG_NONE, SIZE_64);
         OP_ABS32:  d = make_data(SRC_S, RNG_W32, SIZE_32);
         OP_ABS16:  d = make_data(SRC_S, RNG_W16, SIZE_16);
         OP_PREL64: d = make_data(SRC_PREL, RNG_NONE, SIZE_64);
         OP_PREL32: d = make_data(SRC_PREL, RNG_W32, SIZE_32);
         OP_PREL16: d = make_data(SRC_PREL, RNG_W16, SIZE_16);
         OP_LD_PREL_LO19, OP_CONDBR19:
            d = make_insn(SRC_PREL, RNG_S21, 1'b0, 4'd2, 5'd19, IMM_19);
         OP_ADR_PREL_LO21:
            d = make_insn(SRC_PREL, RNG_S21, 1'b0, 4'd0, 5'd21, IMM_ADR);
         OP_ADR_PREL_PG_HI21, OP_TLSDESC_ADR_PAGE21:
            d = make_insn(SRC_PAGE, RNG_S33, 1'b0, 4'd12, 5'd21, IMM_ADR);
         OP_ADR_PREL_PG_HI21_NC:
            d = make_insn(SRC_PAGE, RNG_NONE, 1'b0, 4'd12, 5'd21, IMM_ADR);
         OP_ADD_ABS_LO12_NC, OP_LDST8_ABS_LO12_NC, OP_TLSDESC_ADD_LO12:
            d = make_insn(SRC_S, RNG_NONE, 1'b0, 4'd0, 5'd12, IMM_12);
         OP_LDST16_ABS_LO12_NC:
            d = make_insn(SRC_S, RNG_NONE, 1'b0, 4'd1, 5'd11, IMM_12);
         OP_LDST32_ABS_LO12_NC:
            d = make_insn(SRC_S, RNG_NONE, 1'b0, 4'd2, 5'd10, IMM_12);
         OP_LDST64_ABS_LO12_NC, OP_TLSDESC_LD64_LO12:
            d = make_insn(SRC_S, RNG_NONE, 1'b0, 4'd3, 5'd9, IMM_12);
         OP_LDST128_ABS_LO12_NC:
            d = make_insn(SRC_S, RNG_NONE, 1'b0, 4'd4, 5'd8, IMM_12);
         OP_TSTBR14:
            d = make_insn(SRC_PREL, RNG_S16, 1'b0, 4'd2, 5'd14, IMM_14);
         OP_JUMP26, OP_CALL26: begin
            d = make_insn(SRC_PREL, RNG_NONE, 1'b0, 4'd2, 5'd26, IMM_26);
            d.branch = 1'b1;
         end
         OP_ADR_GOT_PAGE:
            d = make_insn(SRC_GPAGE, RNG_S33, 1'b1, 4'd12, 5'd21, IMM_ADR);
         OP_LD64_GOT_LO12_NC:
            d = make_insn(SRC_G, RNG_NONE, 1'b1, 4'd3, 5'd9, IMM_12);
         OP_LD64_GOTPAGE_LO15:
            d = make_insn(SRC_GREL, RNG_U15, 1'b1, 4'd3, 5'd12, IMM_12);
         OP_TLSLE_ADD_TPREL_HI12:
            d = make_insn(SRC_TLS, RNG_U24, 1'b0, 4'd12, 5'd12, IMM_12);
         OP_TLSLE_ADD_TPREL_LO12_NC:
            d = make_insn(SRC_TLS, RNG_NONE, 1'b0, 4'd0, 5'd12, IMM_12);
         default: d.res = RES_UNSUP;
      endcase
      return d;
   endfunction

   // True for RNG_NONE, else when x + neg, wrapped to 64 bits, lies below neg + pos.
   function automatic logic range_ok(logic [ADDR_W-1:0] x, rng_type rng);
      logic [ADDR_W-1:0] neg;
      logic [ADDR_W-1:0] lim;
      neg = '0;
      lim = '0;
      unique case (rng)
         RNG_W32: begin neg = 64'd1 << 31; lim = (64'd1 << 31) + (64'd1 << 32); end
         RNG_W16: begin neg = 64'd1 << 15; lim = (64'd1 << 15) + (64'd1 << 16); end
         RNG_S21: begin neg = 64'd1 << 20; lim = 64'd1 << 21; end
         RNG_S33: begin neg = 64'd1 << 32; lim = 64'd1 << 33; end
         RNG_S16: begin neg = 64'd1 << 15; lim = 64'd1 << 16; end
         RNG_S28: begin neg = 64'd1 << 27; lim = 64'd1 << 28; end
         RNG_U15: begin neg = '0; lim = 64'd1 << 15; end
         RNG_U24: begin neg = '0; lim = 64'd1 << 24; end
         default: begin neg = '0; lim = '0; end
      endcase
      return (rng == RNG_NONE) || ((x + neg) < lim);
   endfunction

   // TCB size rounded up to the TLS alignment.
   function automatic logic [TCB_W-1:0] tcb_round(logic [ALIGN_W-1:0] a);
      logic [ADDR_W-1:0] a64;
      logic [ADDR_W-1:0] r;
      a64 = {{(ADDR_W-ALIGN_W){1'b0}}, a};
      r   = (TCB_BYTES + a64 - 64'd1) & ~(a64 - 64'd1);
      return r[TCB_W-1:0];
   endfunction

endpackage

>>> rtl/core/arp_decode.sv
// Stage 1: relocation type decode and the address subtractions.
module arp_decode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [arp_pkg::OP_W-1:0]      op,
   input  logic [arp_pkg::ADDR_W-1:0]    sym_plus_addend,
   input  logic [arp_pkg::ADDR_W-1:0]    place_addr,
   input  logic [arp_pkg::WORD_W-1:0]    old_word,
   input  logic [arp_pkg::ADDR_W-1:0]    got_entry_addr,
   input  logic [arp_pkg::ADDR_W-1:0]    veneer_addr,
   input  logic [arp_pkg::ADDR_W-1:0]    got_base,
   input  logic [arp_pkg::TCB_W-1:0]     tcb_rounded,
   output logic                          s1_valid,
   output arp_pkg::s1_type               s1
);

   arp_pkg::s1_type s1_in;
   arp_pkg::s1_type s1_ff;
   logic            s1_valid_ff;
   logic [arp_pkg::ADDR_W-1:0] p_page;

   always_comb begin
      p_page         = place_addr & ~arp_pkg::PAGE_LOW;
      s1_in.dec      = arp_pkg::decode(op);
      s1_in.s        = sym_plus_addend;
      s1_in.prel     = sym_plus_addend - place_addr;
      s1_in.page     = (sym_plus_addend & ~arp_pkg::PAGE_LOW) - p_page;
      s1_in.ven_off  = veneer_addr - place_addr;
      s1_in.v_zero   = (veneer_addr == '0);
      s1_in.gpage    = (got_entry_addr & ~arp_pkg::PAGE_LOW) - p_page;
      s1_in.g        = got_entry_addr;
      s1_in.g_nz     = (got_entry_addr != '0);
      s1_in.grel     = got_entry_addr - (got_base & ~arp_pkg::PAGE_LOW);
      s1_in.tls      = sym_plus_addend
                     + {{(arp_pkg::ADDR_W-arp_pkg::TCB_W){1'b0}}, tcb_rounded};
      s1_in.old_word = old_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

endmodule

>>> rtl/core/arp_check.sv
// Stage 2: value selection, range checks and the branch veneer decision.
module arp_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             s1_valid,
   input  arp_pkg::s1_type  s1,
   output logic             s2_valid,
   output arp_pkg::s2_type  s2
);

   arp_pkg::s2_type s2_in;
   arp_pkg::s2_type s2_ff;
   logic            s2_valid_ff;
   logic [arp_pkg::ADDR_W-1:0] x_sel;
   logic            sel_ok;
   logic            prel_ok;
   logic            ven_ok;

   always_comb begin
      unique case (s1.dec.src)
         arp_pkg::SRC_S:     x_sel = s1.s;
         arp_pkg::SRC_PREL:  x_sel = s1.prel;
         arp_pkg::SRC_PAGE:  x_sel = s1.page;
         arp_pkg::SRC_GPAGE: x_sel = s1.gpage;
         arp_pkg::SRC_G:     x_sel = s1.g;
         arp_pkg::SRC_GREL:  x_sel = s1.grel;
         arp_pkg::SRC_TLS:   x_sel = s1.tls;
         default:            x_sel = s1.s;
      endcase
      sel_ok  = arp_pkg::range_ok(x_sel, s1.dec.rng);
      prel_ok = arp_pkg::range_ok(s1.prel, arp_pkg::RNG_S28);
      ven_ok  = arp_pkg::range_ok(s1.ven_off, arp_pkg::RNG_S28);

      s2_in.res      = s1.dec.res;
      s2_in.wsize    = s1.dec.wsize;
      s2_in.lsb      = s1.dec.lsb;
      s2_in.len      = s1.dec.len;
      s2_in.imm      = s1.dec.imm;
      s2_in.old_word = s1.old_word;
      s2_in.x        = x_sel;
      s2_in.ven      = 1'b0;
      s2_in.ok       = sel_ok && (s1.g_nz || !s1.dec.need_g);

      // An out-of-range branch goes through the veneer when one is supplied.
      if (s1.dec.branch && !prel_ok) begin
         if (s1.v_zero) begin
            s2_in.ok = 1'b0;
         end else begin
            s2_in.x   = s1.ven_off;
            s2_in.ven = 1'b1;
            s2_in.ok  = ven_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
   end

   assign s2_valid = s2_valid_ff;
   assign s2       = s2_ff;

endmodule

>>> rtl/core/arp_merge.sv
// Stage 3: immediate extraction, instruction merge and result formatting.
module arp_merge (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        s2_valid,
   input  arp_pkg::s2_type             s2,
   output logic                        rsp_valid,
   output logic [arp_pkg::ADDR_W-1:0]  rsp_new_value,
   output logic [1:0]                  rsp_write_size,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_used_veneer
);

   logic                       valid_ff;
   logic [arp_pkg::ADDR_W-1:0] value_ff;
   logic [arp_pkg::ADDR_W-1:0] value_in;
   logic [1:0]                 size_ff;
   logic [1:0]                 size_in;
   logic [1:0]                 status_ff;
   logic [1:0]                 status_in;
   logic                       veneer_ff;
   logic                       veneer_in;
   logic [arp_pkg::ADDR_W-1:0] shifted;
   logic [arp_pkg::WORD_W-1:0] fld;
   logic [arp_pkg::WORD_W-1:0] w;
   logic [arp_pkg::WORD_W-1:0] patched;
   logic [arp_pkg::ADDR_W-1:0] data_word;

   always_comb begin
      shifted = s2.x >> s2.lsb;
      fld     = shifted[arp_pkg::WORD_W-1:0] & ((32'd1 << s2.len) - 32'd1);
      w       = s2.old_word;
      unique case (s2.imm)
         arp_pkg::IMM_26:  patched = {w[31:26], fld[25:0]};
         arp_pkg::IMM_19:  patched = {w[31:24], fld[18:0], w[4:0]};
         arp_pkg::IMM_14:  patched = {w[31:19], fld[13:0], w[4:0]};
         arp_pkg::IMM_12:  patched = {w[31:22], fld[11:0], w[9:0]};
         arp_pkg::IMM_ADR: patched = {w[31], fld[1:0], w[28:24], fld[20:2], w[4:0]};
         default:          patched = w;
      endcase

      unique case (s2.wsize)
         arp_pkg::SIZE_16: data_word = {48'd0, s2.x[15:0]};
         arp_pkg::SIZE_32: data_word = {32'd0, s2.x[31:0]};
         arp_pkg::SIZE_64: data_word = s2.x;
         default:          data_word = '0;
      endcase

      value_in  = '0;
      size_in   = arp_pkg::SIZE_NONE;
      status_in = arp_pkg::STAT_OK;
      veneer_in = 1'b0;
      unique case (s2.res)
         arp_pkg::RES_NULL: status_in = arp_pkg::STAT_OK;
         arp_pkg::RES_UNSUP: status_in = arp_pkg::STAT_UNSUP;
         arp_pkg::RES_DATA: begin
            if (s2.ok) begin
               value_in = data_word;
               size_in  = s2.wsize;
            end else begin
               status_in = arp_pkg::STAT_OVF;
            end
         end
         arp_pkg::RES_INSN: begin
            if (s2.ok) begin
               value_in  = {32'd0, patched};
               size_in   = arp_pkg::SIZE_32;
               veneer_in = s2.ven;
            end else begin
               status_in = arp_pkg::STAT_OVF;
            end
         end
         default: status_in = arp_pkg::STAT_UNSUP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      size_ff   <= size_in;
      status_ff <= status_in;
      veneer_ff <= veneer_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_new_value   = value_ff;
   assign rsp_write_size  = size_ff;
   assign rsp_status      = status_ff;
   assign rsp_used_veneer = veneer_ff;

endmodule

>>> rtl/core/arm64_relocation_patcher.sv
// Top level of the AArch64 RELA relocation patcher: configuration registers and pipeline.
//
// The patcher accepts one relocation item per clock cycle whenever start is high and busy
// is low; busy is high only while reset is asserted. Each item produces exactly one result,
// shown on the rsp_ ports with rsp_valid high for a single cycle. Each item passes through
// three register stages (decode and address subtraction, range check and veneer choice,
// immediate merge), and results come out in input order. The receiver cannot stall the
// pipeline, so it must take every result as it appears. Write the csr_ registers only
// when no item is in flight.
module arm64_relocation_patcher (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [arp_pkg::OP_W-1:0]    req_op,
   input  logic [arp_pkg::ADDR_W-1:0]  req_sym_plus_addend,
   input  logic [arp_pkg::ADDR_W-1:0]  req_place_addr,
   input  logic [arp_pkg::WORD_W-1:0]  req_old_word,
   input  logic [arp_pkg::ADDR_W-1:0]  req_got_entry_addr,
   input  logic [arp_pkg::ADDR_W-1:0]  req_veneer_addr,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [arp_pkg::ADDR_W-1:0]  csr_wdata,
   output logic                        rsp_valid,
   output logic [arp_pkg::ADDR_W-1:0]  rsp_new_value,
   output logic [1:0]                  rsp_write_size,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_used_veneer
);

   logic [arp_pkg::ADDR_W-1:0] got_base_ff;
   logic [arp_pkg::TCB_W-1:0]  tcb_ff;
   logic                       accept;
   logic                       s1_valid;
   arp_pkg::s1_type            s1;
   logic                       s2_valid;
   arp_pkg::s2_type            s2;

   assign busy   = reset;
   assign accept = start && !busy;

   // The TLS alignment is kept as the rounded TCB size it implies.
   always_ff @(posedge clock) begin
      if (reset) begin
         got_base_ff <= '0;
         tcb_ff      <= arp_pkg::TCB_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            arp_pkg::CSR_GOT_BASE:  got_base_ff <= csr_wdata;
            arp_pkg::CSR_SEG_ALIGN:
               tcb_ff <= arp_pkg::tcb_round(csr_wdata[arp_pkg::ALIGN_W-1:0]);
            default: got_base_ff <= got_base_ff;
         endcase
      end
   end

   arp_decode u_decode (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (accept),
      .op              (req_op),
      .sym_plus_addend (req_sym_plus_addend),
      .place_addr      (req_place_addr),
      .old_word        (req_old_word),
      .got_entry_addr  (req_got_entry_addr),
      .veneer_addr     (req_veneer_addr),
      .got_base        (got_base_ff),
      .tcb_rounded     (tcb_ff),
      .s1_valid        (s1_valid),
      .s1              (s1)
   );

   arp_check u_check (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1       (s1),
      .s2_valid (s2_valid),
      .s2       (s2)
   );

   arp_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .s2_valid        (s2_valid),
      .s2              (s2),
      .rsp_valid       (rsp_valid),
      .rsp_new_value   (rsp_new_value),
      .rsp_write_size  (rsp_write_size),
      .rsp_status      (rsp_status),
      .rsp_used_veneer (rsp_used_veneer)
   );

endmodule
